// ===== design/pbd_pkg.sv =====
// Package for the pulse rate beat detector: sizes, register indexes and
// controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

  localparam int WINDOW_LEN = 16;
  localparam int PTR_W      = $clog2(WINDOW_LEN);

  localparam int LEVEL_W    = 16;
  localparam int TIME_W     = 32;
  localparam int IVL_W      = 16;
  localparam int RATE_W     = 16;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = LEVEL_W + PTR_W;

  // weighted interval in tenths of ms: 4*iv + 3*prev + 3*older
  localparam int W_W        = 20;
  // (9600000 + w/2) fits in 24 bits
  localparam int NUM_W      = 24;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] RATE_NUM = 24'd9600000;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_OFFSET    = 8'd1;

  typedef struct packed {
    logic capture;
    logic sum_upd;
    logic eval;
    logic weight;
    logic prep;
    logic div_step;
    logic finish;
    logic out_load;
  } pbd_cmd_t;

  typedef struct packed {
    logic beat_now;
  } pbd_stat_t;

endpackage

`default_nettype wire

// ===== design/pbd_if.sv =====
// Channel interfaces of the pulse rate beat detector: input item, result
// item and configuration write. Depends on pbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pbd_in_if
  import pbd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  level;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, level, now_ms, input ready);
  modport sink   (input valid, level, now_ms, output ready);
endinterface

interface pbd_out_if
  import pbd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                beat;
  logic [RATE_W-1:0]   pulse_rate;
  logic [LEVEL_W-1:0]  smoothed_level;
  logic                rising_now;

  modport source (output valid, beat, pulse_rate, smoothed_level, rising_now,
                  input ready);
  modport sink   (input valid, beat, pulse_rate, smoothed_level, rising_now,
                  output ready);
endinterface

interface pbd_cfg_if
  import pbd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/pbd_ctrl.sv =====
// Controller of the pulse rate beat detector: sequences one item through
// sum update, rise evaluation, on a beat weighting and rate division, and result transfer.
// Depends on pbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbd_ctrl
  import pbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire pbd_stat_t stat,
  output pbd_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_EVAL,
    S_WEIGHT,
    S_PREP,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.capture   = in_valid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_upd = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.beat_now ? S_WEIGHT : S_OUT;
      end
      S_WEIGHT: begin
        cmd.weight = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pbd_datapath.sv =====
// Datapath of the pulse rate beat detector: level ring and running sum,
// rise counter, beat intervals, serial rate divider, config and result
// registers. Depends on pbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbd_datapath
  import pbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pbd_cmd_t              cmd,
  output pbd_stat_t                  stat,
  input  wire logic [LEVEL_W-1:0]    in_level,
  input  wire logic [TIME_W-1:0]     in_now_ms,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_beat,
  output logic [RATE_W-1:0]          out_pulse_rate,
  output logic [LEVEL_W-1:0]         out_smoothed_level,
  output logic                       out_rising_now
);

  logic [LEVEL_W-1:0]       level_in_r;
  logic [TIME_W-1:0]        now_in_r;
  logic [LEVEL_W-1:0]       ring_r [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]    ring_vld_r;
  logic [PTR_W-1:0]         ptr_r;
  logic [SUM_W-1:0]         level_sum_r;
  logic [SUM_W-1:0]         prev_sum_r;
  logic [THR_W-1:0]         rise_cnt_r;
  logic                     rising_r;
  logic [TIME_W-1:0]        last_beat_r;
  logic [IVL_W-1:0]         iv_r, iv_prev_r, iv_older_r;
  logic [W_W-1:0]           w_r;
  logic [NUM_W-1:0]         quo_r;
  logic [W_W-1:0]           rem_r;
  logic [RATE_W-1:0]        rate_hold_r;
  logic                     beat_r;
  logic [THR_W-1:0]         thr_r;
  logic signed [RATE_W-1:0] offset_r;

  logic [LEVEL_W-1:0]       ring_rd;
  logic [SUM_W-1:0]         sum_nxt;
  logic                     rise;
  logic [THR_W-1:0]         cnt_inc;
  logic [TIME_W-1:0]        iv_full;
  logic [IVL_W-1:0]         iv_sat;
  logic [W_W-1:0]           w_calc;
  logic [W_W:0]             div_shift, div_diff;
  logic                     div_bit;
  logic [W_W-1:0]           rem_nxt;
  logic signed [NUM_W+1:0]  rate_sum;
  logic [RATE_W-1:0]        rate_nxt;

  assign ring_rd = ring_vld_r[ptr_r] ? ring_r[ptr_r] : '0;
  assign sum_nxt = level_sum_r - SUM_W'(ring_rd) + SUM_W'(level_in_r);

  assign rise    = (level_sum_r > prev_sum_r);
  assign cnt_inc = (rise_cnt_r == '1) ? rise_cnt_r : rise_cnt_r + THR_W'(1);
  assign stat.beat_now = rise && !rising_r && (cnt_inc > thr_r);

  assign iv_full = now_in_r - last_beat_r;
  assign iv_sat  = (iv_full[TIME_W-1:IVL_W] != '0) ? '1 : iv_full[IVL_W-1:0];

  assign w_calc = (W_W'(iv_r) << 2)
                + W_W'(iv_prev_r) + (W_W'(iv_prev_r) << 1)
                + W_W'(iv_older_r) + (W_W'(iv_older_r) << 1);

  assign div_shift = {rem_r, quo_r[NUM_W-1]};
  assign div_diff  = div_shift - {1'b0, w_r};
  assign div_bit   = !div_diff[W_W];
  assign rem_nxt   = div_bit ? div_diff[W_W-1:0] : div_shift[W_W-1:0];

  assign rate_sum = $signed({2'b00, quo_r}) + (NUM_W+2)'(offset_r);

  always_comb begin
    if (w_r == '0) begin
      rate_nxt = '1;
    end else if (rate_sum < 0) begin
      rate_nxt = '0;
    end else if (rate_sum > $signed((NUM_W+2)'(2**RATE_W - 1))) begin
      rate_nxt = '1;
    end else begin
      rate_nxt = rate_sum[RATE_W-1:0];
    end
  end

  // ring storage, no reset: entries read as zero until their valid bit sets
  always_ff @(posedge clk) begin
    if (cmd.sum_upd) ring_r[ptr_r] <= level_in_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      level_in_r <= in_level;
      now_in_r   <= in_now_ms;
    end
    if (cmd.eval && stat.beat_now) iv_r <= iv_sat;
    if (cmd.weight) w_r <= w_calc;
    if (cmd.prep) begin
      quo_r <= RATE_NUM + NUM_W'(w_r >> 1);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUM_W-2:0], div_bit};
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_beat           <= beat_r;
      out_pulse_rate     <= rate_hold_r;
      out_smoothed_level <= level_sum_r[SUM_W-1:PTR_W];
      out_rising_now     <= rising_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r  <= '0;
      ptr_r       <= '0;
      level_sum_r <= '0;
      prev_sum_r  <= '0;
      rise_cnt_r  <= '0;
      rising_r    <= 1'b0;
      last_beat_r <= '0;
      iv_prev_r   <= '0;
      iv_older_r  <= '0;
      rate_hold_r <= '0;
      beat_r      <= 1'b0;
      thr_r       <= THR_W'(4);
      offset_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RISE_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
          REG_RATE_OFFSET:    offset_r <= $signed(cfg_data[RATE_W-1:0]);
          default: ;
        endcase
      end
      if (cmd.sum_upd) begin
        level_sum_r       <= sum_nxt;
        ring_vld_r[ptr_r] <= 1'b1;
        ptr_r <= (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + PTR_W'(1);
      end
      if (cmd.eval) begin
        prev_sum_r <= level_sum_r;
        beat_r     <= stat.beat_now;
        if (rise) begin
          rise_cnt_r <= cnt_inc;
          if (stat.beat_now) begin
            rising_r    <= 1'b1;
            last_beat_r <= now_in_r;
          end
        end else begin
          rise_cnt_r <= '0;
          rising_r   <= 1'b0;
        end
      end
      if (cmd.weight) begin
        iv_older_r <= iv_prev_r;
        iv_prev_r  <= iv_r;
      end
      if (cmd.finish) rate_hold_r <= rate_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pulse_rate_beat_detector_core.sv =====
// Top level of the pulse rate beat detector: joins controller and datapath
// to the input, result and configuration channels.
// Depends on pbd_pkg, pbd_if, pbd_ctrl, pbd_datapath.
//
//   channel  dir  payload                                          transfer
//   in_ch    in   level[15:0], now_ms[31:0]                        valid & ready
//   out_ch   out  beat, pulse_rate[15:0], smoothed_level[15:0],    valid & ready
//                 rising_now
//   cfg_ch   in   index[7:0] (0 rise_threshold, 1 rate_offset),    valid & ready
//                 data[15:0]
//
// One item at a time: an item without a beat passes sum update and rise
// evaluation to result load, one with a beat also weighting, preparation,
// the one-bit-a-cycle restoring rate divider and finish; the next transfer
// can follow in the cycle after the load. The result register lets the next
// item enter while a result waits. Synchronous reset, with no clearing pass,
// clears ring valid bits and state, not data registers. cfg_ch is always ready.
`timescale 1ns / 1ps
`default_nettype none

module pulse_rate_beat_detector_core
  import pbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pbd_in_if.sink     in_ch,
  pbd_out_if.source  out_ch,
  pbd_cfg_if.sink    cfg_ch
);

  pbd_cmd_t  cmd;
  pbd_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  pbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbd_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_level           (in_ch.level),
    .in_now_ms          (in_ch.now_ms),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_beat           (out_ch.beat),
    .out_pulse_rate     (out_ch.pulse_rate),
    .out_smoothed_level (out_ch.smoothed_level),
    .out_rising_now     (out_ch.rising_now)
  );

endmodule

`default_nettype wire

// ===== design/pbd_checker.sv =====
// Port-level checks for pulse_rate_beat_detector_core, attached by bind.
// Depends on pbd_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module pbd_checker
  import pbd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_beat,
  input wire logic [RATE_W-1:0]  out_pulse_rate,
  input wire logic [LEVEL_W-1:0] out_smoothed_level,
  input wire logic               out_rising_now
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pulse_rate) &&
      $stable(out_smoothed_level) && $stable(out_beat) && $stable(out_rising_now))
    else $error("result payload changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_beat_rising: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat |-> out_rising_now)
    else $error("beat without rising flag");

endmodule

bind pulse_rate_beat_detector_core pbd_checker u_pbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_beat           (out_ch.beat),
  .out_pulse_rate     (out_ch.pulse_rate),
  .out_smoothed_level (out_ch.smoothed_level),
  .out_rising_now     (out_ch.rising_now)
);

`default_nettype wire
